[rtl/sva_pkg.sv]
// ----------------------------------------------------------------------------
// sva_pkg: shared constants for the signed vector angle block
// Holds the default coordinate width and the CORDIC step count, zero-vector
// angles and the rotation table.
// ----------------------------------------------------------------------------
package sva_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS    = 20;
    localparam int ZFRAC           = 8;
    localparam int ANGLE_WIDTH     = 15;
    localparam int RIGHT_ANGLE     = 5760;
    localparam int STRAIGHT_ANGLE  = 11520;

    // Rotation angle of each CORDIC step, atan(2^-i) in 1/16384 degree.
    function automatic logic [19:0] rot_angle(input logic [4:0] idx);
        logic [19:0] r;
        begin
            unique case (idx)
                5'd0:    r = 20'd737280;
                5'd1:    r = 20'd435242;
                5'd2:    r = 20'd229970;
                5'd3:    r = 20'd116736;
                5'd4:    r = 20'd58595;
                5'd5:    r = 20'd29326;
                5'd6:    r = 20'd14667;
                5'd7:    r = 20'd7334;
                5'd8:    r = 20'd3667;
                5'd9:    r = 20'd1833;
                5'd10:   r = 20'd917;
                5'd11:   r = 20'd458;
                5'd12:   r = 20'd229;
                5'd13:   r = 20'd115;
                5'd14:   r = 20'd57;
                5'd15:   r = 20'd29;
                5'd16:   r = 20'd14;
                5'd17:   r = 20'd7;
                5'd18:   r = 20'd4;
                5'd19:   r = 20'd2;
                default: r = 20'd0;
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/sva_cordic_stage.sv]
// ----------------------------------------------------------------------------
// sva_cordic_stage: one registered CORDIC vectoring step
// Rotates (x, y) by the fixed step angle toward the x axis and accumulates
// the angle.
// ----------------------------------------------------------------------------
module sva_cordic_stage #(
    parameter int STEP = 0,
    parameter int XW   = 50
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [23:0]   i_z,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [23:0]   o_z
);

    logic signed [XW-1:0] n_x, n_y;
    logic signed [23:0]   n_z;
    logic signed [23:0]   rot;

    // Arithmetic shifts floor; the step direction follows the sign of y.
    always_comb begin
        rot = $signed({4'd0, sva_pkg::rot_angle(5'(STEP))});
        if (i_y > 0) begin
            n_x = i_x + (i_y >>> STEP);
            n_y = i_y - (i_x >>> STEP);
            n_z = i_z + rot;
        end else begin
            n_x = i_x - (i_y >>> STEP);
            n_y = i_y + (i_x >>> STEP);
            n_z = i_z - rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= n_x;
            o_y <= n_y;
            o_z <= n_z;
        end
    end

endmodule

[rtl/sva_isqrt_stage.sv]
// ----------------------------------------------------------------------------
// sva_isqrt_stage: registered digit steps of an integer square root
// Resolves NBIT result bits per stage by restoring compare and subtract.
// ----------------------------------------------------------------------------
module sva_isqrt_stage #(
    parameter int BIT0 = 0,
    parameter int NBIT = 2
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [61:0] i_rem,
    input  logic [30:0] i_root,
    output logic [61:0] o_rem,
    output logic [30:0] o_root
);

    logic [61:0] n_rem;
    logic [30:0] n_root;
    logic [61:0] trial;

    // Each step tries root bit b: needs rem >= (2*root + 2^b) * 2^b.
    always_comb begin
        n_rem  = i_rem;
        n_root = i_root;
        trial  = '0;
        for (int k = NBIT - 1; k >= 0; k--) begin
            trial = (62'(n_root) << (BIT0 + k + 1)) | (62'(1) << (2 * (BIT0 + k)));
            if (n_rem >= trial) begin
                n_rem  = n_rem - trial;
                n_root = n_root | (31'(1) << (BIT0 + k));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_root <= n_root;
        end
    end

endmodule

[rtl/signed_vector_angle.sv]
// ----------------------------------------------------------------------------
// signed_vector_angle: signed angle between a hand vector and a direction
// Pipelined atan2 of cross and dot products with an up-vector sign test.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_valid/o_ready) carries the left and right hand
// points, the base direction and the up vector. The output channel
// (o_valid/i_ready) carries one angle per item in 1/64 degree, -180..180.
// The block is a fixed pipeline of LAT = 35 register stages: hand vector and
// up-dot terms, vector reduction, products, cross sums, joint reduction and
// squares, square sum, eight square-root stages, twenty CORDIC stages and a
// final rounding stage. One item enters per cycle unless the output stalls.
// The whole pipeline advances together when the output stage is empty or is
// taken. While the receiver stalls, every stage holds, o_ready drops and no
// item is lost or repeated.
// Reset clears all valid bits; no result is pending afterwards.
// ----------------------------------------------------------------------------
module signed_vector_angle #(
    parameter int COORD_WIDTH = sva_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_left_x,
    input  logic signed [COORD_WIDTH-1:0] i_left_y,
    input  logic signed [COORD_WIDTH-1:0] i_left_z,
    input  logic signed [COORD_WIDTH-1:0] i_right_x,
    input  logic signed [COORD_WIDTH-1:0] i_right_y,
    input  logic signed [COORD_WIDTH-1:0] i_right_z,
    input  logic signed [COORD_WIDTH-1:0] i_base_x,
    input  logic signed [COORD_WIDTH-1:0] i_base_y,
    input  logic signed [COORD_WIDTH-1:0] i_base_z,
    input  logic signed [COORD_WIDTH-1:0] i_up_x,
    input  logic signed [COORD_WIDTH-1:0] i_up_y,
    input  logic signed [COORD_WIDTH-1:0] i_up_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [sva_pkg::ANGLE_WIDTH-1:0] o_angle
);

    localparam int HW    = COORD_WIDTH + 1;   // hand vector width
    localparam int SHW   = (HW > 17) ? HW - 17 : 0;
    localparam int SBW   = (COORD_WIDTH > 17) ? COORD_WIDTH - 17 : 0;
    localparam int PW    = 34;                // product of two 17-bit values
    localparam int UPW   = COORD_WIDTH + HW;  // up-dot product width
    localparam int UPS   = UPW + 2;
    localparam int SQW   = 36;                // cross/dot sums after reduction
    localparam int NST   = sva_pkg::CORDIC_STEPS;
    localparam int XW    = 50;
    localparam int NSQ   = 8;
    localparam int LAT   = 6 + NSQ + NST + 1;

    // Pipeline advances when the last stage is empty or taken.
    logic adv;
    logic [LAT-1:0] r_vld;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ---------------- stage 1: hand vector and up dot terms ----------------
    logic signed [HW-1:0]  r1_h [3];
    logic signed [COORD_WIDTH-1:0] r1_b [3];
    logic signed [UPW-1:0] r1_up [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_h[0]  <= HW'(i_right_x) - HW'(i_left_x);
            r1_h[1]  <= HW'(i_right_y) - HW'(i_left_y);
            r1_h[2]  <= HW'(i_right_z) - HW'(i_left_z);
            r1_b[0]  <= i_base_x;
            r1_b[1]  <= i_base_y;
            r1_b[2]  <= i_base_z;
            r1_up[0] <= UPW'(i_up_x) * UPW'(HW'(i_right_x) - HW'(i_left_x));
            r1_up[1] <= UPW'(i_up_y) * UPW'(HW'(i_right_y) - HW'(i_left_y));
            r1_up[2] <= UPW'(i_up_z) * UPW'(HW'(i_right_z) - HW'(i_left_z));
        end
    end

    // ---------------- stage 2: zero test, sign, vector reduction ----------------
    function automatic logic [4:0] vshift(input logic [31:0] m0, input logic [31:0] m1,
                                          input logic [31:0] m2);
        logic [31:0] o;
        logic [4:0]  s;
        begin
            o = (m0 | m1 | m2) >> 16;
            s = 5'd0;
            for (int k = 0; k < 16; k++) begin
                if (o[k]) s = 5'(k + 1);
            end
            return s;
        end
    endfunction

    function automatic logic [31:0] amag(input logic signed [32:0] v);
        return (v < 0) ? 32'(-v) : 32'(v);
    endfunction

    logic signed [16:0] n2_h [3], n2_b [3];
    logic [31:0] hm [3], bm [3];
    logic [31:0] hr [3], br [3];
    logic [4:0]  hs, bs;
    logic signed [UPS-1:0] upsum;
    logic        n2_zero, n2_neg;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hm[k] = amag(33'(r1_h[k]));
            bm[k] = amag(33'(r1_b[k]));
        end
        hs = (SHW > 0) ? vshift(hm[0], hm[1], hm[2]) : 5'd0;
        bs = (SBW > 0) ? vshift(bm[0], bm[1], bm[2]) : 5'd0;
        for (int k = 0; k < 3; k++) begin
            hr[k] = hm[k] >> hs;
            br[k] = bm[k] >> bs;
            n2_h[k] = r1_h[k] < 0 ? -$signed({1'b0, hr[k][15:0]}) : $signed({1'b0, hr[k][15:0]});
            n2_b[k] = r1_b[k] < 0 ? -$signed({1'b0, br[k][15:0]}) : $signed({1'b0, br[k][15:0]});
        end
        n2_zero = (r1_h[0] == 0 && r1_h[1] == 0 && r1_h[2] == 0) ||
                  (r1_b[0] == 0 && r1_b[1] == 0 && r1_b[2] == 0);
        upsum  = UPS'(r1_up[0]) + UPS'(r1_up[1]) + UPS'(r1_up[2]);
        n2_neg = upsum > 0;
    end

    logic signed [16:0] r2_h [3], r2_b [3];
    logic [LAT-1:0] r_zero, r_neg;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_h <= n2_h;
            r2_b <= n2_b;
        end
    end

    // Zero and sign flags ride beside the data; bit k belongs to stage k.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_zero <= {r_zero[LAT-2:2], n2_zero, 2'b00};
            r_neg  <= {r_neg[LAT-2:2], n2_neg, 2'b00};
        end
    end

    // ---------------- stage 3: products ----------------
    logic signed [PW-1:0] r3_p [12];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_p[0]  <= PW'(r2_h[0]) * PW'(r2_b[0]);
            r3_p[1]  <= PW'(r2_h[1]) * PW'(r2_b[1]);
            r3_p[2]  <= PW'(r2_h[2]) * PW'(r2_b[2]);
            r3_p[3]  <= PW'(r2_h[1]) * PW'(r2_b[2]);
            r3_p[4]  <= PW'(r2_h[2]) * PW'(r2_b[1]);
            r3_p[5]  <= PW'(r2_h[2]) * PW'(r2_b[0]);
            r3_p[6]  <= PW'(r2_h[0]) * PW'(r2_b[2]);
            r3_p[7]  <= PW'(r2_h[0]) * PW'(r2_b[1]);
            r3_p[8]  <= PW'(r2_h[1]) * PW'(r2_b[0]);
            r3_p[9]  <= '0;
            r3_p[10] <= '0;
            r3_p[11] <= '0;
        end
    end

    // ---------------- stage 4: dot and cross sums, magnitudes ----------------
    logic signed [SQW-1:0] d4, c4 [3];
    always_comb begin
        d4    = SQW'(r3_p[0]) + SQW'(r3_p[1]) + SQW'(r3_p[2]) + SQW'(r3_p[9]);
        c4[0] = SQW'(r3_p[3]) - SQW'(r3_p[4]) + SQW'(r3_p[10]);
        c4[1] = SQW'(r3_p[5]) - SQW'(r3_p[6]) + SQW'(r3_p[11]);
        c4[2] = SQW'(r3_p[7]) - SQW'(r3_p[8]);
    end

    logic [SQW-1:0] r4_m [4];
    logic [LAT-1:0] r_dneg;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_m[0] <= d4 < 0 ? SQW'(-d4) : SQW'(d4);
            for (int k = 0; k < 3; k++) r4_m[k+1] <= c4[k] < 0 ? SQW'(-c4[k]) : SQW'(c4[k]);
            r_dneg <= {r_dneg[LAT-2:4], d4 < 0, 4'b0000};
        end
    end

    // ---------------- stage 5: joint reduction below 2^30, squares ----------------
    logic [SQW-1:0] or5;
    logic [2:0]     s5;
    logic [29:0]    m5 [4];
    always_comb begin
        or5 = (r4_m[0] | r4_m[1] | r4_m[2] | r4_m[3]) >> 30;
        s5  = 3'd0;
        for (int k = 0; k < 6; k++) begin
            if (or5[k]) s5 = 3'(k + 1);
        end
        for (int k = 0; k < 4; k++) m5[k] = 30'(r4_m[k] >> s5);
    end

    logic [29:0] r5_x;
    logic [59:0] r5_sq [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_x <= m5[0];
            for (int k = 0; k < 3; k++) r5_sq[k] <= 60'(m5[k+1]) * 60'(m5[k+1]);
        end
    end

    // ---------------- square root stages ----------------
    logic [61:0] sq_rem  [NSQ+1];
    logic [30:0] sq_root [NSQ+1];
    logic [29:0] sx [NSQ+1];
    logic [29:0] r6_x;
    logic [61:0] r6_s;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_x <= r5_x;
            r6_s <= 62'(r5_sq[0]) + 62'(r5_sq[1]) + 62'(r5_sq[2]);
        end
    end
    assign sq_rem[0]  = r6_s;
    assign sq_root[0] = '0;
    assign sx[0]      = r6_x;

    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        sva_isqrt_stage #(
            .BIT0 (31 - 4 * (g + 1) < 0 ? 0 : 31 - 4 * (g + 1)),
            .NBIT (31 - 4 * (g + 1) < 0 ? 31 - 4 * g : 4)
        ) u_sq (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (adv) sx[g+1] <= sx[g];
        end
    end

    // ---------------- CORDIC stages ----------------
    logic signed [XW-1:0] cx [NST+1], cy [NST+1];
    logic signed [23:0]   cz [NST+1];
    assign cx[0] = $signed(XW'({sx[NSQ], 16'd0}));
    assign cy[0] = $signed(XW'({sq_root[NSQ], 16'd0}));
    assign cz[0] = '0;

    for (genvar g = 0; g < NST; g++) begin : g_cordic
        sva_cordic_stage #(.STEP(g), .XW(XW)) u_st (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_x   (cx[g]),
            .i_y   (cy[g]),
            .i_z   (cz[g]),
            .o_x   (cx[g+1]),
            .o_y   (cy[g+1]),
            .o_z   (cz[g+1])
        );
    end

    // ---------------- final stage: clamp, round, fold, sign ----------------
    localparam logic signed [23:0] ZMAX = 24'(sva_pkg::RIGHT_ANGLE << sva_pkg::ZFRAC);
    logic signed [23:0] zc;
    logic [15:0] mag, res_m;
    logic signed [15:0] res;
    always_comb begin
        zc = cz[NST];
        if (zc < 0) zc = '0;
        if (zc > ZMAX) zc = ZMAX;
        mag = 16'((zc + 24'sd128) >>> sva_pkg::ZFRAC);
        if (r_zero[LAT-1]) begin
            res_m = 16'(sva_pkg::RIGHT_ANGLE);
        end else if (r_dneg[LAT-1]) begin
            res_m = 16'(sva_pkg::STRAIGHT_ANGLE) - mag;
        end else begin
            res_m = mag;
        end
        res = r_neg[LAT-1] ? -$signed(res_m) : $signed(res_m);
    end

    always_ff @(posedge i_clk) begin
        if (adv) o_angle <= res[sva_pkg::ANGLE_WIDTH-1:0];
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for signed_vector_angle
// Drives hand points, base and up vectors through the valid/ready input,
// takes each angle from the directed table or a local fixed-point atan2
// model and compares every output transfer in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = sva_pkg::COORD_WIDTH_DEF;
    localparam int AW        = sva_pkg::ANGLE_WIDTH;
    localparam int N_RANDOM  = 1850;
    localparam int LAT       = 35;
    localparam int MAX_CYC   = 400000;
    localparam int N_DIR     = 22;
    localparam logic signed [CW-1:0] CMAX = 16'sh7fff;
    localparam logic signed [CW-1:0] CMIN = 16'sh8000;

    // Sentinel in the directed table: no typed-in angle, use the predictor.
    localparam int NO_ANGLE = 99999;

    typedef logic signed [CW-1:0] coord_t;
    typedef struct {
        coord_t c[12];
    } item_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        i_ready = 1'b0;
    coord_t      crd[12];
    logic signed [AW-1:0] o_angle;

    int          angle_q[$];
    int          errors = 0;
    int          n_checked = 0;
    int          cycles = 0;
    bit          stim_done = 1'b0;

    // Rotation constants of the CORDIC steps, in 1/16384 degree.
    longint rot_const[20] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667,
                              7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2};

    initial for (int k = 0; k < 12; k++) crd[k] = '0;

    always #5 i_clk = ~i_clk;

    signed_vector_angle u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_left_x(crd[0]), .i_left_y(crd[1]), .i_left_z(crd[2]),
        .i_right_x(crd[3]), .i_right_y(crd[4]), .i_right_z(crd[5]),
        .i_base_x(crd[6]), .i_base_y(crd[7]), .i_base_z(crd[8]),
        .i_up_x(crd[9]), .i_up_y(crd[10]), .i_up_z(crd[11]),
        .o_valid(o_valid), .i_ready(i_ready), .o_angle(o_angle)
    );

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint iabs(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Scales a vector down as a whole until every magnitude fits 16 bits.
    function automatic void reduce_vec(ref longint v[3]);
        longint m[3];
        for (int k = 0; k < 3; k++) m[k] = iabs(v[k]);
        while (m[0] >= 65536 || m[1] >= 65536 || m[2] >= 65536)
            for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
        for (int k = 0; k < 3; k++) v[k] = v[k] < 0 ? -m[k] : m[k];
    endfunction

    function automatic longint int_sqrt(longint s);
        longint r = 0;
        longint b = 64'sh1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Predicts the signed angle in 1/64 degree for one item.
    function automatic int predict_angle(item_t it);
        longint h[3], b[3], u[3];
        longint d, c0, c1, c2, ax, m0, m1, m2, x, y, z, dx, dy, hu, res;
        for (int k = 0; k < 3; k++) begin
            h[k] = longint'(it.c[3+k]) - longint'(it.c[k]);
            b[k] = longint'(it.c[6+k]);
            u[k] = longint'(it.c[9+k]);
        end
        // The sign test uses the unreduced hand vector and fits in 64 bits.
        hu = u[0]*h[0] + u[1]*h[1] + u[2]*h[2];
        if ((h[0] == 0 && h[1] == 0 && h[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
            res = sva_pkg::RIGHT_ANGLE;
        end else begin
            reduce_vec(h);
            reduce_vec(b);
            d  = h[0]*b[0] + h[1]*b[1] + h[2]*b[2];
            c0 = h[1]*b[2] - h[2]*b[1];
            c1 = h[2]*b[0] - h[0]*b[2];
            c2 = h[0]*b[1] - h[1]*b[0];
            ax = iabs(d); m0 = iabs(c0); m1 = iabs(c1); m2 = iabs(c2);
            while (ax >= (64'sd1 << 30) || m0 >= (64'sd1 << 30) ||
                   m1 >= (64'sd1 << 30) || m2 >= (64'sd1 << 30)) begin
                ax = ax >> 1; m0 = m0 >> 1; m1 = m1 >> 1; m2 = m2 >> 1;
            end
            x = ax << 16;
            y = int_sqrt(m0*m0 + m1*m1 + m2*m2) << 16;
            z = 0;
            for (int i = 0; i < 20; i++) begin
                dx = fshr(y, i);
                dy = fshr(x, i);
                if (y > 0) begin
                    x = x + dx; y = y - dy; z = z + rot_const[i];
                end else begin
                    x = x - dx; y = y + dy; z = z - rot_const[i];
                end
            end
            if (z < 0) z = 0;
            if (z > (longint'(sva_pkg::RIGHT_ANGLE) << 8)) z = longint'(sva_pkg::RIGHT_ANGLE) << 8;
            z = (z + 128) >>> 8;
            res = d < 0 ? sva_pkg::STRAIGHT_ANGLE - z : z;
        end
        if (hu > 0) res = -res;
        return int'(res);
    endfunction

    function automatic item_t make_item(coord_t l0, coord_t l1, coord_t l2, coord_t r0,
                                        coord_t r1, coord_t r2, coord_t b0, coord_t b1,
                                        coord_t b2, coord_t u0, coord_t u1, coord_t u2);
        item_t it;
        it.c = '{l0, l1, l2, r0, r1, r2, b0, b1, b2, u0, u1, u2};
        return it;
    endfunction

    // Random item: small or full-range coordinates, some degenerate.
    function automatic item_t rand_item();
        item_t it;
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 12; k++) begin
            if (mode < 4) it.c[k] = coord_t'($urandom_range(0, 400)) - 200;
            else it.c[k] = coord_t'($urandom);
        end
        if (mode == 8) for (int k = 0; k < 3; k++) it.c[3+k] = it.c[k];
        if (mode == 9) for (int k = 6; k < 9; k++) it.c[k] = '0;
        if ($urandom_range(0, 7) == 0) begin
            // Parallel or antiparallel base along the hand vector.
            for (int k = 0; k < 3; k++) begin
                it.c[k] = coord_t'($urandom_range(0, 2000)) - 1000;
                it.c[3+k] = coord_t'($urandom_range(0, 2000)) - 1000;
                it.c[6+k] = ($urandom_range(0, 1) ? 1 : -1) * (it.c[3+k] - it.c[k]);
            end
        end
        return it;
    endfunction

    function automatic int gap_len();
        return $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) < 8 ?
               $urandom_range(1, 3) : $urandom_range(10, 40));
    endfunction

    // Presents one item and holds it until the transfer.
    task automatic send_item(item_t it, int exp_angle);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        for (int k = 0; k < 12; k++) crd[k] <= it.c[k];
        i_valid <= 1'b1;
        angle_q.push_back(exp_angle == NO_ANGLE ? predict_angle(it) : exp_angle);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Directed table: extremes, zero vectors, sign test, parallel cases.
    item_t dir_item[N_DIR];
    int    dir_angle[N_DIR];

    initial begin
        dir_item[0]  = make_item(0,0,0, 0,0,0, 0,0,0, 0,0,0);  dir_angle[0] = 5760;
        dir_item[1]  = make_item(0,0,0, 1,0,0, 1,0,0, 0,0,0);  dir_angle[1] = 0;
        dir_item[2]  = make_item(0,0,0, 1,0,0, -1,0,0, 0,0,0); dir_angle[2] = 11520;
        dir_item[3]  = make_item(0,0,0, 1,0,0, 0,1,0, 0,0,0);  dir_angle[3] = 5760;
        dir_item[4]  = make_item(0,0,0, 1,0,0, -1,0,0, 1,0,0); dir_angle[4] = -11520;
        dir_item[5]  = make_item(0,0,0, 1,0,0, 0,0,0, 1,0,0);  dir_angle[5] = -5760;
        dir_item[6]  = make_item(5,5,5, 5,5,5, 1,2,3, 7,7,7);  dir_angle[6] = 5760;
        dir_item[7]  = make_item(0,0,0, 1,0,0, 1,0,0, -1,0,0); dir_angle[7] = 0;
        dir_item[8]  = make_item(CMIN,CMIN,CMIN, CMAX,CMAX,CMAX, CMAX,CMAX,CMAX,
                                 CMAX,CMAX,CMAX); dir_angle[8] = 0;
        dir_item[9]  = make_item(CMAX,CMAX,CMAX, CMIN,CMIN,CMIN, CMAX,CMAX,CMAX,
                                 CMIN,CMIN,CMIN); dir_angle[9] = -11520;
        dir_item[10] = make_item(CMIN,0,0, CMAX,0,0, 0,CMIN,0, CMAX,0,0);
        dir_angle[10] = -5760;
        dir_item[11] = make_item(0,0,0, 1,1,0, 1,0,0, 0,0,0);  dir_angle[11] = 2880;
        dir_item[12] = make_item(0,0,0, 1,1,0, -1,0,0, 0,0,0); dir_angle[12] = 8640;
        dir_item[13] = make_item(0,0,0, 3,4,0, 0,0,1, 0,0,5);  dir_angle[13] = 5760;
        dir_item[14] = make_item(CMAX,CMIN,CMAX, CMIN,CMAX,CMIN, 1,-1,1, 1,1,1);
        dir_angle[14] = NO_ANGLE;
        dir_item[15] = make_item(100,-200,300, -400,500,-600, CMIN,CMAX,CMIN,
                                 3,-2,1); dir_angle[15] = NO_ANGLE;
        dir_item[16] = make_item(0,0,0, 1,2,3, 3,2,1, -1,-1,-1); dir_angle[16] = NO_ANGLE;
        dir_item[17] = make_item(-1,-1,-1, 0,0,0, 1,0,0, 0,0,0); dir_angle[17] = NO_ANGLE;
        dir_item[18] = make_item(0,0,0, CMAX,1,0, 1,CMAX,0, 0,0,CMAX);
        dir_angle[18] = NO_ANGLE;
        dir_item[19] = make_item(0,0,0, 0,0,1, 0,0,CMIN, 0,0,0); dir_angle[19] = 11520;
        dir_item[20] = make_item(CMAX,CMAX,CMAX, CMAX,CMAX,CMAX, CMAX,0,0, 0,0,0);
        dir_angle[20] = 5760;
        dir_item[21] = make_item(0,0,0, 2,1,0, 0,0,0, -1,0,0);  dir_angle[21] = 5760;
    end

    // Stimulus: reset, directed table, then random items.
    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < N_DIR; n++) send_item(dir_item[n], dir_angle[n]);
        for (int n = 0; n < N_RANDOM; n++) send_item(rand_item(), NO_ANGLE);
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver idling: random ready gaps, with stall-free stretches.
    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            if (cycles > 6000 && cycles < 7000) begin
                i_ready <= 1'b1;
            end else begin
                g = gap_len();
                if (g == 0) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready <= 1'b0;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Check every output transfer against the oldest expected angle.
    always @(posedge i_clk) begin
        int exp_a;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (angle_q.size() == 0) begin
                $display("%0t: unexpected angle transfer, expected none, actual %0d",
                         $time, o_angle);
                errors++;
            end else begin
                exp_a = angle_q.pop_front();
                if (int'(o_angle) != exp_a) begin
                    $display("%0t: angle mismatch, expected %0d, actual %0d",
                             $time, exp_a, o_angle);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    // End of run: drain, settle, report; or time out.
    initial begin
        while (!(stim_done && angle_q.size() == 0) && cycles < MAX_CYC) @(posedge i_clk);
        if (cycles >= MAX_CYC) begin
            $display("%0t: timeout with %0d angles outstanding", $time, angle_q.size());
            $display("** signed_vector_angle: FAILED **");
        end else begin
            repeat (2 * LAT) @(posedge i_clk);
            $display("Checked %0d angles from %0d directed and %0d random items,",
                     n_checked, N_DIR, N_RANDOM);
            $display("with random idling on both channels; %0d mismatches.", errors);
            if (errors == 0) begin
                $display("** signed_vector_angle: PASSED **");
            end else begin
                $display("** signed_vector_angle: FAILED **");
            end
        end
        $finish;
    end
endmodule
